FILE: rtl/core/tsr_pkg.sv
package tsr_pkg;

   localparam int TSR_BUFFER_BYTES = 2048;
   localparam logic [11:0] TSR_CAPACITY_RESET = 12'd2048;

   typedef enum logic [2:0] {
      OP_HEADER  = 3'd0,
      OP_PAYLOAD = 3'd1,
      OP_EMPTY   = 3'd2,
      OP_READ    = 3'd3,
      OP_CLEAR   = 3'd4
   } opcode_type;

   typedef enum logic [3:0] {
      ST_ACCEPTED  = 4'd0,
      ST_COMPLETE  = 4'd1,
      ST_NO_HEADER = 4'd2,
      ST_NO_FIR    = 4'd3,
      ST_BAD_SEQ   = 4'd4,
      ST_OVERFLOW  = 4'd5,
      ST_DISCARDED = 4'd6,
      ST_READ      = 4'd7,
      ST_CLEARED   = 4'd8
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
      logic [7:0]  payload_length;
      logic [10:0] read_index;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [11:0] fragment_length;
      logic [7:0]  read_data;
      logic [5:0]  expected_sequence;
      logic [31:0] accepted_segments;
      logic [31:0] rejected_segments;
   } rsp_payload_type;

   // buffer access issued for one word
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic rd_in_range;
   } mem_cmd_type;

endpackage

FILE: rtl/core/tsr_ram.sv
module tsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tsr_ctrl.sv
module tsr_ctrl #(
   parameter int BUFFER_BYTES = tsr_pkg::TSR_BUFFER_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  tsr_pkg::req_payload_type        req,
   input  logic [11:0]                     capacity,
   output tsr_pkg::rsp_payload_type        meta,
   output tsr_pkg::mem_cmd_type            mem_cmd,
   output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
   output logic [7:0]                      wr_data,
   output logic [$clog2(BUFFER_BYTES)-1:0] rd_addr
);
   import tsr_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int MW = (CW > 12) ? CW : 12;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_RECEIVE = 2'd1,
      MODE_DISCARD = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] wpos_ff, wpos_in;
   logic [7:0]  to_come_ff, to_come_in;
   logic        fin_pend_ff, fin_pend_in;
   logic [5:0]  seq_ff, seq_in;
   logic [31:0] ok_ff, ok_in;
   logic [31:0] err_ff, err_in;

   // header evaluation
   logic          hdr_fir;
   logic          hdr_fin;
   logic [5:0]    hdr_seq;
   logic [CW-1:0] held_v;
   logic [5:0]    seq_v;
   logic [MW-1:0] cap_eff;
   logic [MW-1:0] room;
   status_type    reject;
   // payload evaluation
   logic [CW-1:0] wpos_v;
   logic [7:0]    to_come_v;
   status_type    status;
   logic [11:0]   frag_len;

   assign hdr_fir = req.data_byte[6];
   assign hdr_fin = req.data_byte[7];
   assign hdr_seq = req.data_byte[5:0];

   always_comb begin
      held_v = held_ff;
      seq_v  = seq_ff;
      reject = ST_ACCEPTED;
      if (hdr_fir) begin
         seq_v  = hdr_seq;
         held_v = '0;
      end else if (held_ff == '0) begin
         reject = ST_NO_FIR;
      end else if (hdr_seq != seq_ff) begin
         reject = ST_BAD_SEQ;
      end
      cap_eff = (MW'(capacity) > MW'(BUFFER_BYTES)) ? MW'(BUFFER_BYTES) : MW'(capacity);
      room    = (MW'(held_v) >= cap_eff) ? '0 : cap_eff - MW'(held_v);
      if (reject == ST_ACCEPTED && MW'(req.payload_length) > room) begin
         reject = ST_OVERFLOW;
         held_v = '0;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      held_in     = held_ff;
      wpos_in     = wpos_ff;
      to_come_in  = to_come_ff;
      fin_pend_in = fin_pend_ff;
      seq_in      = seq_ff;
      ok_in       = ok_ff;
      err_in      = err_ff;
      status      = ST_DISCARDED;
      frag_len    = '0;
      mem_cmd     = '0;
      wpos_v      = wpos_ff;
      to_come_v   = to_come_ff;
      unique case (req.opcode)
         OP_HEADER: begin
            mode_in     = MODE_IDLE;
            to_come_in  = '0;
            fin_pend_in = 1'b0;
            held_in     = held_v;
            wpos_in     = held_v;
            seq_in      = seq_v;
            if (reject != ST_ACCEPTED) begin
               err_in = err_ff + 32'd1;
               status = reject;
               if (req.payload_length != '0) begin
                  mode_in    = MODE_DISCARD;
                  to_come_in = req.payload_length;
               end
            end else begin
               ok_in = ok_ff + 32'd1;
               if (req.payload_length == '0) begin
                  seq_in = seq_v + 6'd1;
                  if (hdr_fin) begin
                     status   = ST_COMPLETE;
                     frag_len = 12'(held_v);
                     held_in  = '0;
                     wpos_in  = '0;
                  end else begin
                     status = ST_ACCEPTED;
                  end
               end else begin
                  mode_in     = MODE_RECEIVE;
                  to_come_in  = req.payload_length;
                  fin_pend_in = hdr_fin;
                  status      = ST_ACCEPTED;
               end
            end
         end
         OP_PAYLOAD: begin
            if (mode_ff == MODE_RECEIVE && to_come_ff != '0) begin
               if (wpos_ff < CW'(BUFFER_BYTES)) begin
                  mem_cmd.wr_en = 1'b1;
                  wpos_v        = wpos_ff + CW'(1);
               end
               to_come_v = to_come_ff - 8'd1;
               if (to_come_v == '0) begin
                  mode_in     = MODE_IDLE;
                  to_come_in  = '0;
                  fin_pend_in = 1'b0;
                  seq_in      = seq_ff + 6'd1;
                  if (fin_pend_ff) begin
                     status   = ST_COMPLETE;
                     frag_len = 12'(wpos_v);
                     held_in  = '0;
                     wpos_in  = '0;
                  end else begin
                     status  = ST_ACCEPTED;
                     held_in = wpos_v;
                     wpos_in = wpos_v;
                  end
               end else begin
                  status     = ST_ACCEPTED;
                  wpos_in    = wpos_v;
                  to_come_in = to_come_v;
               end
            end else if (mode_ff == MODE_DISCARD && to_come_ff != '0) begin
               to_come_in = to_come_ff - 8'd1;
               if (to_come_ff == 8'd1) begin
                  mode_in = MODE_IDLE;
               end
            end
         end
         OP_EMPTY: begin
            mode_in     = MODE_IDLE;
            to_come_in  = '0;
            fin_pend_in = 1'b0;
            wpos_in     = held_ff;
            err_in      = err_ff + 32'd1;
            status      = ST_NO_HEADER;
         end
         OP_READ: begin
            mem_cmd.rd_en       = 1'b1;
            mem_cmd.rd_in_range = 32'(req.read_index) < 32'(BUFFER_BYTES);
            status              = ST_READ;
         end
         OP_CLEAR: begin
            mode_in     = MODE_IDLE;
            to_come_in  = '0;
            fin_pend_in = 1'b0;
            held_in     = '0;
            wpos_in     = '0;
            seq_in      = '0;
            status      = ST_CLEARED;
         end
         default: begin
            status = ST_DISCARDED;
         end
      endcase
      if (!accept) begin
         mem_cmd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         held_ff     <= '0;
         wpos_ff     <= '0;
         to_come_ff  <= '0;
         fin_pend_ff <= 1'b0;
         seq_ff      <= '0;
         ok_ff       <= '0;
         err_ff      <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         held_ff     <= held_in;
         wpos_ff     <= wpos_in;
         to_come_ff  <= to_come_in;
         fin_pend_ff <= fin_pend_in;
         seq_ff      <= seq_in;
         ok_ff       <= ok_in;
         err_ff      <= err_in;
      end
   end

   assign wr_addr = wpos_ff[AW-1:0];
   assign wr_data = req.data_byte;
   assign rd_addr = AW'(req.read_index);

   always_comb begin
      meta                   = '0;
      meta.status            = status;
      meta.fragment_length   = frag_len;
      meta.expected_sequence = seq_in;
      meta.accepted_segments = ok_in;
      meta.rejected_segments = err_in;
   end

   // an open segment always has bytes still to come
   a_mode_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) == (to_come_ff == '0))
      else $error("segment mode and byte count disagree");

   // uncommitted bytes never sit below the committed fill
   a_wpos_held: assert property (@(posedge clock) disable iff (reset)
      wpos_ff >= held_ff)
      else $error("write position behind committed bytes");

endmodule

FILE: rtl/core/transport_segment_reassembler_unit.sv
// transport segment reassembler
// req_ channel: one word per item (segment header, payload byte, empty
//   segment, fragment byte read, clear); req_ready is high whenever the
//   first pipeline stage is free or moving on, so one word per cycle is taken
// rsp_ channel: exactly one result word per request word, in order; carries
//   the status, the completed fragment length, read data, the expected
//   sequence and both segment counters as they stand after that word
// csr_ channel: writes the fragment capacity; always ready, and only to be
//   used while no request word is in flight
// pipeline: a result word passes through stage 1 and then the output register
//   before it shows on rsp_valid; throughput is one word per cycle while the
//   receiver does not stall, set by the single write port / single read port
//   of the fragment buffer and the turnaround of the segment state registers
// reset: segment state, sequence, counters and pipeline valids clear and the
//   capacity returns to 2048; the buffer contents are left as they are
// receiver stall: the output register holds its word, the stage in front of
//   it holds its word and buffer read data; req_ready drops once it is full
module transport_segment_reassembler_unit #(
   parameter int BUFFER_BYTES = tsr_pkg::TSR_BUFFER_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tsr_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tsr_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [11:0]              csr_data
);
   import tsr_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);

   logic            accept;
   logic            s1_move;
   logic [11:0]     capacity_ff;
   rsp_payload_type meta;
   mem_cmd_type     mem_cmd;
   logic [AW-1:0]   wr_addr;
   logic [7:0]      wr_data;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      ram_rd_data;

   // stage 1: result fields known, buffer read in flight
   logic            s1_valid_ff, s1_valid_in;
   rsp_payload_type s1_meta_ff;
   logic            s1_rd_ok_ff;
   // stage 2: output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_payload_ff, out_payload_in;

   assign csr_ready = 1'b1;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= TSR_CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   // handshake: stage 1 drains into the output register when that is free or emptying
   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // segment state and buffer commands
   tsr_ctrl #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .capacity (capacity_ff),
      .meta     (meta),
      .mem_cmd  (mem_cmd),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr)
   );

   // fragment buffer; each word issues at most one access, so a read always
   // comes after any earlier write and no bypass is needed
   tsr_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_BYTES)
   ) u_fragment_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      // out-of-range reads answer zero
      out_payload_in           = s1_meta_ff;
      out_payload_in.read_data = s1_rd_ok_ff ? ram_rd_data : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff  <= meta;
         s1_rd_ok_ff <= mem_cmd.rd_in_range;
      end
      if (s1_move) begin
         out_payload_ff <= out_payload_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   // a taken word always lands in stage 1
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost before stage 1");

   // read data of a held stage 1 word must not change under it
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> $stable(ram_rd_data))
      else $error("buffer read data changed while stage 1 stalled");

   // one buffer access per word
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("buffer read and write in the same cycle");

   // no word may be taken while stage 1 is stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !accept)
      else $error("word taken over a stalled stage 1");

endmodule

FILE: tb/sv/tb_transport_segment_reassembler_unit.sv
`timescale 1ns / 1ps

module tb_transport_segment_reassembler_unit;
   import tsr_pkg::*;

   localparam int BUF_BYTES      = TSR_BUFFER_BYTES;
   localparam int RESULT_LATENCY = 2;
   localparam int QUIET_LIMIT    = 3000;
   localparam int MAX_REPORTS    = 200;
   localparam int HOLD_CYCLES    = 150;

   typedef enum logic [1:0] {
      SEG_IDLE,
      SEG_RECEIVE,
      SEG_DISCARD
   } seg_mode_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [11:0]     csr_data;

   transport_segment_reassembler_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   // reassembly state as the block should hold it
   logic [7:0]   frag_bytes [BUF_BYTES];
   int unsigned  frag_held;
   int unsigned  frag_wpos;
   int unsigned  frag_high_water;   // every position below this has been written
   int unsigned  seg_left;
   seg_mode_type seg_mode;
   bit           seg_fin;
   logic [5:0]   seq_due;
   logic [31:0]  good_segments;
   logic [31:0]  bad_segments;
   logic [11:0]  cap_setting;

   rsp_payload_type results_due [$];
   rsp_payload_type due_word;

   int failures;
   int items_sent;
   int quiet_cycles = 0;
   bit send_idle_on;
   bit recv_idle_on;
   int rsp_hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // reassembly predictor
   // ---------------------------------------------------------------------

   function automatic void reset_model();
      frag_held       = 0;
      frag_wpos       = 0;
      frag_high_water = 0;
      seg_left        = 0;
      seg_mode        = SEG_IDLE;
      seg_fin         = 1'b0;
      seq_due         = '0;
      good_segments   = '0;
      bad_segments    = '0;
      cap_setting     = TSR_CAPACITY_RESET;
   endfunction

   // open segment is dropped, uncommitted bytes with it
   function automatic void drop_open_segment();
      seg_mode  = SEG_IDLE;
      seg_left  = 0;
      seg_fin   = 1'b0;
      frag_wpos = frag_held;
   endfunction

   // commit the segment, step the sequence, report the fragment on final
   function automatic status_type end_segment(output int unsigned flen);
      bit fin;
      fin       = seg_fin;
      flen      = 0;
      frag_held = frag_wpos;
      seq_due   = seq_due + 6'd1;
      seg_mode  = SEG_IDLE;
      seg_left  = 0;
      seg_fin   = 1'b0;
      if (fin) begin
         flen      = frag_held;
         frag_held = 0;
         frag_wpos = 0;
         return ST_COMPLETE;
      end
      return ST_ACCEPTED;
   endfunction

   // capacity above the buffer acts as the buffer size
   function automatic int unsigned room_left_bytes();
      int unsigned cap;
      cap = (cap_setting > BUF_BYTES) ? BUF_BYTES : cap_setting;
      return (frag_held >= cap) ? 0 : cap - frag_held;
   endfunction

   function automatic status_type take_header(input logic [7:0] hdr, input logic [7:0] len,
                                              output int unsigned flen);
      status_type verdict;
      verdict = ST_ACCEPTED;
      flen    = 0;
      drop_open_segment();
      if (hdr[6]) begin
         seq_due   = hdr[5:0];
         frag_held = 0;
         frag_wpos = 0;
      end else if (frag_held == 0) begin
         verdict = ST_NO_FIR;
      end else if (hdr[5:0] != seq_due) begin
         verdict = ST_BAD_SEQ;
      end
      if (verdict == ST_ACCEPTED && len > room_left_bytes()) begin
         verdict   = ST_OVERFLOW;
         frag_held = 0;
         frag_wpos = 0;
      end
      if (verdict != ST_ACCEPTED) begin
         bad_segments++;
         if (len > 0) begin
            seg_mode = SEG_DISCARD;
            seg_left = len;
         end
         return verdict;
      end
      good_segments++;
      seg_fin = hdr[7];
      if (len == 0)
         return end_segment(flen);
      seg_mode = SEG_RECEIVE;
      seg_left = len;
      return ST_ACCEPTED;
   endfunction

   function automatic status_type take_payload(input logic [7:0] value,
                                               output int unsigned flen);
      flen = 0;
      if (seg_mode == SEG_RECEIVE && seg_left > 0) begin
         if (frag_wpos < BUF_BYTES) begin
            frag_bytes[frag_wpos] = value;
            frag_wpos++;
            if (frag_wpos > frag_high_water)
               frag_high_water = frag_wpos;
         end
         seg_left--;
         if (seg_left == 0)
            return end_segment(flen);
         return ST_ACCEPTED;
      end
      if (seg_mode == SEG_DISCARD && seg_left > 0) begin
         seg_left--;
         if (seg_left == 0)
            seg_mode = SEG_IDLE;
      end
      return ST_DISCARDED;
   endfunction

   function automatic rsp_payload_type reassemble_word(input req_payload_type w);
      rsp_payload_type r;
      int unsigned     flen;
      r        = '0;
      flen     = 0;
      r.status = ST_DISCARDED;
      case (w.opcode)
         OP_HEADER:  r.status = take_header(w.data_byte, w.payload_length, flen);
         OP_PAYLOAD: r.status = take_payload(w.data_byte, flen);
         OP_EMPTY: begin
            drop_open_segment();
            bad_segments++;
            r.status = ST_NO_HEADER;
         end
         OP_READ: begin
            r.read_data = frag_bytes[w.read_index];
            r.status    = ST_READ;
         end
         OP_CLEAR: begin
            drop_open_segment();
            frag_held = 0;
            frag_wpos = 0;
            seq_due   = '0;
            r.status  = ST_CLEARED;
         end
         default: ;
      endcase
      r.fragment_length   = flen[11:0];
      r.expected_sequence = seq_due;
      r.accepted_segments = good_segments;
      r.rejected_segments = bad_segments;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", field, want, got);
      end
   endfunction

   // results are matched before this edge's request is predicted, so a word
   // can never be checked against its own prediction in the same cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("result word with nothing expected");
            end else begin
               due_word = results_due.pop_front();
               check_field("status", due_word.status, rsp_payload.status);
               check_field("fragment_length", due_word.fragment_length,
                           rsp_payload.fragment_length);
               check_field("read_data", due_word.read_data, rsp_payload.read_data);
               check_field("expected_sequence", due_word.expected_sequence,
                           rsp_payload.expected_sequence);
               check_field("accepted_segments", due_word.accepted_segments,
                           rsp_payload.accepted_segments);
               check_field("rejected_segments", due_word.rejected_segments,
                           rsp_payload.rejected_segments);
            end
         end
         if (csr_valid && csr_ready)
            cap_setting = csr_data;
         if (req_valid && req_ready)
            results_due.push_back(reassemble_word(req_payload));
      end
   end

   // watchdog: too long without any word moving on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** transport_segment_reassembler_unit: FAILED **");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // receiver: random stall bursts, plus a long hold on request
   // ---------------------------------------------------------------------

   initial begin
      int hold;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold             = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else
            rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------

   // valid stays up between back-to-back words; it only drops for a gap or
   // when a test phase ends
   task automatic send_word(input opcode_type op, input logic [7:0] data,
                            input logic [7:0] len, input logic [10:0] idx);
      req_payload_type w;
      w.opcode         = op;
      w.data_byte      = data;
      w.payload_length = len;
      w.read_index     = idx;
      if (send_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      if (op <= OP_CLEAR)
         items_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_header(input logic [7:0] hdr, input logic [7:0] len);
      send_word(OP_HEADER, hdr, len, 11'($urandom));
   endtask

   task automatic send_payload(input logic [7:0] value);
      send_word(OP_PAYLOAD, value, 8'($urandom), 11'($urandom));
   endtask

   task automatic send_read(input logic [10:0] idx);
      send_word(OP_READ, 8'($urandom), 8'($urandom), idx);
   endtask

   function automatic logic [7:0] hdr_byte(input bit fin, input bit fir, input logic [5:0] seq);
      return {fin, fir, seq};
   endfunction

   // reads only ever touch positions that have been written
   task automatic send_read_any();
      if (frag_high_water > 0)
         send_read(11'($urandom_range(0, frag_high_water - 1)));
      else
         send_word(OP_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [11:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // a run of segments from a first one on, mostly well formed; now and then
   // a wrong sequence or a flipped first flag, and the last may be cut short
   task automatic send_fragment(input int unsigned segments, input bit cut);
      logic [5:0]  seq;
      logic [7:0]  hdr;
      int unsigned len;
      int unsigned sent;
      seq = 6'($urandom);
      for (int unsigned s = 0; s < segments; s++) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
         hdr = hdr_byte(s == segments - 1 && $urandom_range(0, 3) != 0, s == 0, seq);
         if ($urandom_range(0, 24) == 0)
            hdr[5:0] = 6'($urandom);
         if ($urandom_range(0, 24) == 0)
            hdr[6] = ~hdr[6];
         send_header(hdr, len[7:0]);
         sent = (cut && s == segments - 1) ? $urandom_range(0, len) : len;
         repeat (sent) send_payload(8'($urandom));
         seq = seq + 6'd1;
      end
   endtask

   task automatic send_noise_word();
      opcode_type op;
      op = opcode_type'(3'($urandom_range(0, 7)));
      if (op == OP_READ)
         send_read_any();
      else
         send_word(op, 8'($urandom), 8'($urandom), 11'($urandom));
   endtask

   task automatic send_random_burst();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         send_fragment($urandom_range(1, 4), 1'b0);
      else if (pick < 75)
         send_fragment($urandom_range(1, 3), 1'b1);
      else if (pick < 85)
         repeat ($urandom_range(1, 3)) send_read_any();
      else
         send_noise_word();
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   task automatic test_directed_cases();
      // first and final in one header with no payload: empty fragment
      send_header(hdr_byte(1'b1, 1'b1, 6'd63), 8'd0);
      // three bytes, then a final segment of two: five-byte fragment
      send_header(hdr_byte(1'b0, 1'b1, 6'd5), 8'd3);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'h5A);
      send_header(hdr_byte(1'b1, 1'b0, 6'd6), 8'd2);
      send_payload(8'hA5);
      send_payload(8'h3C);
      send_read(11'd0);
      send_read(11'd4);
      // no first flag with nothing held: its bytes are thrown away
      send_header(hdr_byte(1'b0, 1'b0, 6'd7), 8'd2);
      send_payload(8'h11);
      send_payload(8'h22);
      // byte with no segment open
      send_payload(8'h33);
      // out-of-sequence segment
      send_header(hdr_byte(1'b0, 1'b1, 6'd10), 8'd1);
      send_payload(8'h77);
      send_header(hdr_byte(1'b0, 1'b0, 6'd20), 8'd0);
      // empty segment abandons the open one
      send_header(hdr_byte(1'b0, 1'b1, 6'd0), 8'd4);
      send_payload(8'h01);
      send_word(OP_EMPTY, 8'hC3, 8'h81, 11'h555);
      // length beyond the usual maximum is taken as given
      send_header(hdr_byte(1'b0, 1'b1, 6'd1), 8'd255);
      send_payload(8'h80);
      send_word(OP_CLEAR, 8'h3C, 8'h7E, 11'h2AA);
      // opcodes with no meaning
      send_word(opcode_type'(3'd5), 8'hFF, 8'hFF, 11'h7FF);
      send_word(opcode_type'(3'd6), 8'h00, 8'h00, 11'h000);
      send_word(opcode_type'(3'd7), 8'h96, 8'h69, 11'h3A5);
   endtask

   task automatic test_capacity_limits();
      // no room at all: any payload overflows, an empty fragment still fits
      write_capacity(12'd0);
      send_header(hdr_byte(1'b0, 1'b1, 6'd3), 8'd1);
      send_payload(8'h42);
      send_header(hdr_byte(1'b1, 1'b1, 6'd3), 8'd0);
      // one byte of room
      write_capacity(12'd1);
      send_header(hdr_byte(1'b0, 1'b1, 6'd9), 8'd1);
      send_payload(8'h99);
      send_header(hdr_byte(1'b0, 1'b0, 6'd10), 8'd1);
      send_payload(8'h98);
      // capacity lowered below what is already held
      write_capacity(12'd8);
      send_header(hdr_byte(1'b0, 1'b1, 6'd40), 8'd8);
      repeat (8) send_payload(8'($urandom));
      write_capacity(12'd4);
      send_header(hdr_byte(1'b0, 1'b0, 6'd41), 8'd0);
      send_header(hdr_byte(1'b1, 1'b0, 6'd42), 8'd1);
      send_payload(8'h24);
      // beyond the buffer size
      write_capacity(12'd4095);
      send_header(hdr_byte(1'b1, 1'b1, 6'd0), 8'd4);
      repeat (4) send_payload(8'($urandom));
   endtask

   // fragment past the 1 KiB mark so the top index bit is read back
   task automatic test_long_fragment();
      logic [5:0] seq;
      write_capacity(12'd1030);
      seq = 6'($urandom);
      for (int s = 0; s < 5; s++) begin
         send_header(hdr_byte(1'b0, s == 0, seq), 8'd206);
         repeat (206) send_payload(8'($urandom));
         seq = seq + 6'd1;
      end
      // capacity exactly used up: a final empty segment still completes it
      send_header(hdr_byte(1'b1, 1'b0, seq), 8'd0);
      send_read(11'd1023);
      send_read(11'd1024);
      send_read(11'd1029);
      repeat (4) send_read(11'($urandom_range(1024, 1029)));
      write_capacity(TSR_CAPACITY_RESET);
   endtask

   // receiver holds off long enough for the pipeline to back up into req_
   task automatic test_backpressure();
      int stop_at;
      drain_results();
      send_idle_on     = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      stop_at          = items_sent + 60;
      while (items_sent < stop_at) send_fragment($urandom_range(1, 3), 1'b0);
      send_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int phases, input int per_phase);
      int stop_at;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0:       write_capacity(TSR_CAPACITY_RESET);
            1:       write_capacity(12'd4095);
            2:       write_capacity(12'($urandom_range(1, 40)));
            default: write_capacity(12'($urandom_range(41, 800)));
         endcase
         stop_at = items_sent + per_phase;
         while (items_sent < stop_at) send_random_burst();
      end
   endtask

   // last stretch at full rate on both sides
   task automatic test_steady_stream();
      drain_results();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      test_random_traffic(1, 150);
   endtask

   initial begin
      failures         = 0;
      items_sent       = 0;
      send_idle_on     = 1'b1;
      recv_idle_on     = 1'b1;
      rsp_hold_request = 0;
      reset_model();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_capacity_limits();
      test_long_fragment();
      test_backpressure();
      test_random_traffic(4, 105);
      test_steady_stream();

      drain_results();
      if (failures == 0 && results_due.size() == 0)
         $display("** transport_segment_reassembler_unit: PASSED **");
      else
         $display("** transport_segment_reassembler_unit: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/tsr_pkg.sv
rtl/core/tsr_ram.sv
rtl/core/tsr_ctrl.sv
rtl/core/transport_segment_reassembler_unit.sv
tb/sv/tb_transport_segment_reassembler_unit.sv
